/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHBS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication failed");

// Next-cycle implication, disabled during reset.
`define CHBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication failed");

`endif

/* hw/rtl/chbs_pkg.sv */
`timescale 1ns / 1ps

package chbs_pkg;

   localparam int MAX_BINS = 64;
   localparam int MIN_BINS = 3;
   localparam int ADDR_W   = $clog2(MAX_BINS);
   localparam int CNT_W    = ADDR_W + 1;
   localparam int VAL_W    = 32;
   localparam int SUM_W    = VAL_W + 2;
   localparam int PASS_W   = 6;

   // divide by three one 17-bit digit at a time
   localparam int DIGIT_W     = SUM_W / 2;
   localparam int DIV_IN_W    = DIGIT_W + 2;
   localparam int RECIP_SHIFT = DIV_IN_W + 2;
   localparam int RECIP_W     = RECIP_SHIFT - 1;
   localparam logic [RECIP_W-1:0] DIV3_RECIP = RECIP_W'(((1 << RECIP_SHIFT) + 2) / 3);

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = CNT_W;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_IN_USE     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITERATION_COUNT = 1'b1;

   localparam logic [CNT_W-1:0]  RESET_BINS_IN_USE     = CNT_W'(36);
   localparam logic [PASS_W-1:0] RESET_ITERATION_COUNT = PASS_W'(6);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_FIRST,
      ST_RD_LAST,
      ST_LD_LAST,
      ST_RD_NEXT,
      ST_SUM,
      ST_DIV_HI,
      ST_DIV_LO,
      ST_EMIT
   } state_type;

endpackage

/* hw/rtl/circular_histogram_box_smoother.sv */
// Load: one bin per cycle, start taken whenever busy is low.
// After the last bin of a histogram (N bins, P passes) busy stays high; once the P passes are
// done, N result strobes follow on consecutive cycles. Each pass reads bins 0 and N-1, then
// steps each bin through RD_NEXT, SUM, DIV_HI, DIV_LO on the one shared divide-by-three unit.
// Synchronous active-high reset: idle, load count zero, registers to 36 bins and 6 passes.
// The bin store is not cleared by reset. Results cannot be stalled by the receiver.
`timescale 1ns / 1ps

module circular_histogram_box_smoother import chbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VAL_W-1:0]      req_bin_value,
   output logic                  rsp_strobe,
   output logic [VAL_W-1:0]      rsp_smoothed_value,
   output logic [ADDR_W-1:0]     rsp_bin_index,
   output logic                  rsp_last_bin,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

`include "assert_macros.svh"

   state_type state_ff, state_in;

   logic [CNT_W-1:0]   bins_in_use_ff;
   logic [PASS_W-1:0]  iteration_count_ff;
   logic [CNT_W-1:0]   load_count_ff, load_count_in;
   logic [CNT_W-1:0]   job_bins_ff, job_bins_in;
   logic [PASS_W-1:0]  job_passes_ff, job_passes_in;
   logic [ADDR_W-1:0]  k_ff, k_in;
   logic [PASS_W-1:0]  pass_ff, pass_in;
   logic [VAL_W-1:0]   first_ff, first_in;
   logic [VAL_W-1:0]   left_ff, left_in;
   logic [VAL_W-1:0]   mid_ff, mid_in;
   logic [VAL_W-1:0]   right_ff, right_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [DIGIT_W-1:0] qhi_ff, qhi_in;
   logic [DIV_IN_W-1:0] x_ff, x_in;
   logic               emit_v_ff, emit_v_in;
   logic [ADDR_W-1:0]  emit_idx_ff, emit_idx_in;
   logic               emit_last_ff, emit_last_in;

   logic [CNT_W-1:0]   eff_bins;
   logic [CNT_W-1:0]   last_k;
   logic               at_last_k;
   logic               accept;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [VAL_W-1:0]   ram_wr_data;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [VAL_W-1:0]   ram_rd_data;

   logic [DIV_IN_W-1:0] div_a;
   logic [DIGIT_W-1:0]  div_q;
   logic [1:0]          div_r;
   logic [SUM_W-1:0]    quot_full;
   logic [VAL_W-1:0]    right_val;

   chbs_bin_ram #(.DEPTH(MAX_BINS), .WIDTH(VAL_W)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   chbs_div3 u_div3 (
      .dividend  (div_a),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      if (bins_in_use_ff < CNT_W'(MIN_BINS)) begin
         eff_bins = CNT_W'(MIN_BINS);
      end else if (bins_in_use_ff > CNT_W'(MAX_BINS)) begin
         eff_bins = CNT_W'(MAX_BINS);
      end else begin
         eff_bins = bins_in_use_ff;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign last_k    = job_bins_ff - CNT_W'(1);
   assign at_last_k = ({1'b0, k_ff} == last_k);
   assign right_val = at_last_k ? first_ff : ram_rd_data;
   assign quot_full = {qhi_ff, DIGIT_W'(0)} + SUM_W'(div_q);

   always_ff @(posedge clock) begin
      if (reset) begin
         bins_in_use_ff     <= RESET_BINS_IN_USE;
         iteration_count_ff <= RESET_ITERATION_COUNT;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_BINS_IN_USE: begin
               bins_in_use_ff <= csr_write_data;
            end
            CSR_ITERATION_COUNT: begin
               iteration_count_ff <= csr_write_data[PASS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_count_ff <= '0;
         emit_v_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         emit_v_ff     <= emit_v_in;
      end
   end

   always_ff @(posedge clock) begin
      job_bins_ff   <= job_bins_in;
      job_passes_ff <= job_passes_in;
      k_ff          <= k_in;
      pass_ff       <= pass_in;
      first_ff      <= first_in;
      left_ff       <= left_in;
      mid_ff        <= mid_in;
      right_ff      <= right_in;
      sum_ff        <= sum_in;
      qhi_ff        <= qhi_in;
      x_ff          <= x_in;
      emit_idx_ff   <= emit_idx_in;
      emit_last_ff  <= emit_last_in;
   end

   always_comb begin
      logic [CNT_W-1:0] load_next;
      load_next     = load_count_ff + CNT_W'(1);
      state_in      = state_ff;
      load_count_in = load_count_ff;
      job_bins_in   = job_bins_ff;
      job_passes_in = job_passes_ff;
      k_in          = k_ff;
      pass_in       = pass_ff;
      first_in      = first_ff;
      left_in       = left_ff;
      mid_in        = mid_ff;
      right_in      = right_ff;
      sum_in        = sum_ff;
      qhi_in        = qhi_ff;
      x_in          = x_ff;
      emit_v_in     = 1'b0;
      emit_idx_in   = emit_idx_ff;
      emit_last_in  = emit_last_ff;
      ram_we        = 1'b0;
      ram_wr_addr   = load_count_ff[ADDR_W-1:0];
      ram_wr_data   = req_bin_value;
      ram_rd_addr   = k_ff;
      div_a         = {2'b00, sum_ff[SUM_W-1 -: DIGIT_W]};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ram_we = 1'b1;
               if (load_next >= eff_bins) begin
                  load_count_in = '0;
                  job_bins_in   = eff_bins;
                  job_passes_in = iteration_count_ff;
                  k_in          = '0;
                  pass_in       = '0;
                  state_in      = (iteration_count_ff == '0) ? ST_EMIT : ST_RD_FIRST;
               end else begin
                  load_count_in = load_next;
               end
            end
         end
         ST_RD_FIRST: begin
            ram_rd_addr = '0;
            state_in    = ST_RD_LAST;
         end
         ST_RD_LAST: begin
            first_in    = ram_rd_data;
            mid_in      = ram_rd_data;
            ram_rd_addr = last_k[ADDR_W-1:0];
            state_in    = ST_LD_LAST;
         end
         ST_LD_LAST: begin
            left_in  = ram_rd_data;
            k_in     = '0;
            state_in = ST_RD_NEXT;
         end
         ST_RD_NEXT: begin
            ram_rd_addr = k_ff + ADDR_W'(1);
            state_in    = ST_SUM;
         end
         ST_SUM: begin
            right_in = right_val;
            sum_in   = SUM_W'(left_ff) + SUM_W'(mid_ff) + SUM_W'(right_val) + SUM_W'(1);
            state_in = ST_DIV_HI;
         end
         ST_DIV_HI: begin
            div_a    = {2'b00, sum_ff[SUM_W-1 -: DIGIT_W]};
            qhi_in   = div_q;
            x_in     = {div_r, sum_ff[DIGIT_W-1:0]};
            state_in = ST_DIV_LO;
         end
         ST_DIV_LO: begin
            div_a       = x_ff;
            ram_we      = 1'b1;
            ram_wr_addr = k_ff;
            ram_wr_data = quot_full[VAL_W-1:0];
            left_in     = mid_ff;
            mid_in      = right_ff;
            if (at_last_k) begin
               pass_in = pass_ff + PASS_W'(1);
               k_in    = '0;
               if (pass_ff + PASS_W'(1) == job_passes_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_RD_FIRST;
               end
            end else begin
               k_in     = k_ff + ADDR_W'(1);
               state_in = ST_RD_NEXT;
            end
         end
         ST_EMIT: begin
            ram_rd_addr  = k_ff;
            emit_v_in    = 1'b1;
            emit_idx_in  = k_ff;
            emit_last_in = at_last_k;
            k_in         = k_ff + ADDR_W'(1);
            if (at_last_k) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe         = emit_v_ff;
   assign rsp_smoothed_value = ram_rd_data;
   assign rsp_bin_index      = emit_idx_ff;
   assign rsp_last_bin       = emit_v_ff && emit_last_ff;

   `CHBS_ASSERT_IMPLIES(a_strobe_from_emit, clock, reset, emit_v_ff, $past(state_ff == ST_EMIT))
   `CHBS_ASSERT_IMPLIES(a_bin_in_range, clock, reset,
      (state_ff == ST_EMIT || state_ff == ST_SUM || state_ff == ST_DIV_LO),
      ({1'b0, k_ff} < job_bins_ff))
   `CHBS_ASSERT_IMPLIES(a_pass_in_range, clock, reset,
      (state_ff == ST_DIV_HI || state_ff == ST_DIV_LO), (pass_ff < job_passes_ff))
   `CHBS_ASSERT_NEXT(a_last_ends_job, clock, reset,
      (state_ff == ST_EMIT && at_last_k), (state_ff == ST_IDLE && emit_last_ff))

endmodule

/* hw/rtl/chbs_bin_ram.sv */
`timescale 1ns / 1ps

module chbs_bin_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/chbs_div3.sv */
`timescale 1ns / 1ps

module chbs_div3 import chbs_pkg::*; (
   input  logic [DIV_IN_W-1:0] dividend,
   output logic [DIGIT_W-1:0]  quotient,
   output logic [1:0]          remainder
);

   localparam int PROD_W = DIV_IN_W + RECIP_W;

   logic [PROD_W-1:0]   product;
   logic [DIV_IN_W-1:0] back;

   // reciprocal multiply, exact for dividends below 3 * 2**DIGIT_W
   assign product   = PROD_W'(dividend) * PROD_W'(DIV3_RECIP);
   assign quotient  = product[RECIP_SHIFT +: DIGIT_W];
   assign back      = dividend - DIV_IN_W'(quotient) * DIV_IN_W'(3);
   assign remainder = back[1:0];

endmodule

/* tb/tb_circular_histogram_box_smoother.sv */
`timescale 1ns / 1ps

module tb_circular_histogram_box_smoother import chbs_pkg::*; ();

   typedef struct {
      logic [VAL_W-1:0]  value;
      logic [ADDR_W-1:0] index;
      logic              last;
   } bin_result_type;

   typedef enum {ROW_WRITE, ROW_BIN} row_kind_type;

   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic [VAL_W-1:0]      bin;
      bit                    typed;
      logic [VAL_W-1:0]      want;
   } plan_row_type;

   localparam int PLAN_ROWS     = 25;
   localparam int RANDOM_ITEMS  = 200;
   localparam int MAX_BIN_COUNT = 127;
   localparam int MAX_PASSES    = 63;

   // bins loaded under the reset setting, then the count is cut below the load position
   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'h0000_0000, 1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'h0001_0000, 1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'h8000_0000, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_BINS_IN_USE,     7'd2,  32'h0,         1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'h0000_0001, 1'b0, 32'h0},
      // zero passes: bins come back unchanged
      '{ROW_WRITE, CSR_ITERATION_COUNT, 7'd0,  32'h0,         1'b0, 32'h0},
      '{ROW_WRITE, CSR_BINS_IN_USE,     7'd3,  32'h0,         1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'h0000_0000, 1'b1, 32'h0000_0000},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'hA5A5_5A5A, 1'b1, 32'hA5A5_5A5A},
      // flat full-scale histogram stays full scale
      '{ROW_WRITE, CSR_ITERATION_COUNT, 7'd63, 32'h0,         1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
      '{ROW_WRITE, CSR_BINS_IN_USE,     7'd4,  32'h0,         1'b0, 32'h0},
      '{ROW_WRITE, CSR_ITERATION_COUNT, 7'd1,  32'h0,         1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'hFFFF_FFFF, 1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'h0000_0000, 1'b0, 32'h0},
      '{ROW_WRITE, CSR_BINS_IN_USE,     7'd0,  32'h0,         1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'h0000_0002, 1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'h0000_0001, 1'b0, 32'h0},
      '{ROW_BIN,   CSR_BINS_IN_USE,     7'd0,  32'h0000_0000, 1'b0, 32'h0}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [VAL_W-1:0]      req_bin_value;
   logic                  rsp_strobe;
   logic [VAL_W-1:0]      rsp_smoothed_value;
   logic [ADDR_W-1:0]     rsp_bin_index;
   logic                  rsp_last_bin;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // predicted block state
   logic [VAL_W-1:0]      model_bins [MAX_BINS];
   logic [VAL_W-1:0]      typed_val [MAX_BINS];
   bit                    typed_on [MAX_BINS];
   int                    model_load;
   logic [CNT_W-1:0]      model_bin_count;
   logic [PASS_W-1:0]     model_passes;

   bin_result_type        awaited_bins [$];
   int                    failures;
   bit                    idle_on;

   circular_histogram_box_smoother i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_bin_value      (req_bin_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_smoothed_value (rsp_smoothed_value),
      .rsp_bin_index      (rsp_bin_index),
      .rsp_last_bin       (rsp_last_bin),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic int effective_bins();
      int n;
      n = int'(model_bin_count);
      if (n < MIN_BINS) n = MIN_BINS;
      if (n > MAX_BINS) n = MAX_BINS;
      return n;
   endfunction

   task automatic absorb_bin(input logic [VAL_W-1:0] v, input bit typed,
                             input logic [VAL_W-1:0] want);
      int n;
      logic [VAL_W-1:0] prev [MAX_BINS];
      logic [SUM_W-1:0] sum;
      bin_result_type r;
      n = effective_bins();
      if (model_load < MAX_BINS) begin
         model_bins[model_load] = v;
         typed_on[model_load] = typed;
         typed_val[model_load] = want;
      end
      model_load = (model_load + 1) % 128;
      if (model_load < n) return;
      model_load = 0;
      repeat (int'(model_passes)) begin
         prev = model_bins;
         for (int k = 0; k < n; k++) begin
            sum = SUM_W'(prev[(k == 0) ? n - 1 : k - 1]) + SUM_W'(prev[k])
                + SUM_W'(prev[(k + 1 == n) ? 0 : k + 1]);
            model_bins[k] = VAL_W'((sum + 1) / 3);
         end
      end
      for (int k = 0; k < n; k++) begin
         r.value = typed_on[k] ? typed_val[k] : model_bins[k];
         r.index = ADDR_W'(k);
         r.last  = (k + 1 == n);
         awaited_bins.push_back(r);
         typed_on[k] = 1'b0;
      end
   endtask

   task automatic load_bin(input logic [VAL_W-1:0] v, input bit typed = 1'b0,
                           input logic [VAL_W-1:0] want = '0);
      while (idle_on && $urandom_range(0, 99) < 21) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_bin_value <= v;
      do @(posedge clock); while (busy);
      absorb_bin(v, typed, want);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      start <= 1'b0;
      @(posedge clock);
      while (awaited_bins.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_BINS_IN_USE) model_bin_count = data;
      else model_passes = PASS_W'(data);
   endtask

   function automatic logic [VAL_W-1:0] random_bin();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 32'hFFFF_FFFF - $urandom_range(0, 255);
         2: return $urandom_range(0, 32'h0003_FFFF);
         default: return $urandom;
      endcase
   endfunction

   always @(posedge clock) begin
      bin_result_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_bins.size() == 0) begin
            $error("unexpected result: smoothed_value %h bin_index %0d",
                   rsp_smoothed_value, rsp_bin_index);
            failures++;
         end else begin
            want = awaited_bins.pop_front();
            if (rsp_smoothed_value !== want.value) begin
               $error("smoothed_value: expected %h, actual %h", want.value, rsp_smoothed_value);
               failures++;
            end
            if (rsp_bin_index !== want.index) begin
               $error("bin_index: expected %0d, actual %0d", want.index, rsp_bin_index);
               failures++;
            end
            if (rsp_last_bin !== want.last) begin
               $error("last_bin: expected %0b, actual %0b", want.last, rsp_last_bin);
               failures++;
            end
         end
      end
   end

   initial begin
      int random_items;
      int hist;
      int shrink_at;
      bit shrink;
      failures = 0;
      model_load = 0;
      model_bin_count = RESET_BINS_IN_USE;
      model_passes = RESET_ITERATION_COUNT;
      foreach (typed_on[k]) typed_on[k] = 1'b0;
      idle_on = 1'b1;
      reset <= 1'b1;
      start <= 1'b0;
      req_bin_value <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_BINS_IN_USE;
      csr_write_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].data);
         else load_bin(plan[i].bin, plan[i].typed, plan[i].want);
      end

      random_items = 0;
      hist = 0;
      while (random_items < RANDOM_ITEMS) begin
         idle_on = !(hist >= 6 && hist < 11);
         if (hist == 0) begin
            write_reg(CSR_BINS_IN_USE, CNT_W'(MAX_BINS));
            write_reg(CSR_ITERATION_COUNT, CSR_DATA_W'($urandom_range(1, 4)));
         end else if (hist == 1) begin
            write_reg(CSR_BINS_IN_USE, CNT_W'($urandom_range(MAX_BINS + 1, MAX_BIN_COUNT)));
            write_reg(CSR_ITERATION_COUNT, CSR_DATA_W'(MAX_PASSES));
         end else begin
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 24))
                  0, 1: write_reg(CSR_BINS_IN_USE, CNT_W'($urandom_range(0, MIN_BINS - 1)));
                  2:    write_reg(CSR_BINS_IN_USE, CNT_W'($urandom_range(MAX_BINS,
                                                                         MAX_BIN_COUNT)));
                  default: write_reg(CSR_BINS_IN_USE, CNT_W'($urandom_range(MIN_BINS, 12)));
               endcase
            end
            if ($urandom_range(0, 1) == 1) begin
               if ($urandom_range(0, 9) == 0)
                  write_reg(CSR_ITERATION_COUNT, CSR_DATA_W'(MAX_PASSES));
               else
                  write_reg(CSR_ITERATION_COUNT, CSR_DATA_W'($urandom_range(0, 8)));
            end
         end
         // occasionally rewrite the bin count in the middle of a load
         shrink = ($urandom_range(0, 6) == 0);
         shrink_at = $urandom_range(1, effective_bins() - 1);
         do begin
            load_bin(random_bin());
            random_items++;
            if (shrink && model_load == shrink_at) begin
               write_reg(CSR_BINS_IN_USE, CNT_W'($urandom_range(0, 2 * shrink_at)));
               shrink = 1'b0;
            end
         end while (model_load != 0);
         hist++;
      end

      start <= 1'b0;
      while (awaited_bins.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

/* circular_histogram_box_smoother.f */
+incdir+hw/rtl
hw/rtl/chbs_pkg.sv
hw/rtl/chbs_bin_ram.sv
hw/rtl/chbs_div3.sv
hw/rtl/circular_histogram_box_smoother.sv
tb/tb_circular_histogram_box_smoother.sv
